@@ design/cdq_pkg.sv @@
// Shared types and codes for the circular double-ended queue.
package cdq_pkg;

  localparam int WORD_W   = 32;
  localparam int OPCODE_W = 3;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [OPCODE_W-1:0]      opcode_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [STATUS_W-1:0]      status_t;

  // operation codes; unused codes act as status only
  localparam opcode_t OP_INS_FRONT = 3'd0;
  localparam opcode_t OP_INS_REAR  = 3'd1;
  localparam opcode_t OP_DEL_FRONT = 3'd2;
  localparam opcode_t OP_DEL_REAR  = 3'd3;
  localparam opcode_t OP_STATUS    = 3'd4;

  // result status codes
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_OVERFLOW  = 2'd1;
  localparam status_t STAT_UNDERFLOW = 2'd2;

  // value shown for front and rear while empty
  localparam word_t EMPTY_VALUE = '1;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } cdq_state_t;

endpackage

@@ design/cdq_if.sv @@
// Handshake channels of the queue: operation words in, result words out.
interface cdq_in_if;
  import cdq_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  word_t   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;

  logic    valid;
  logic    ready;
  word_t   front_value;
  word_t   rear_value;
  count_t  count;
  logic    is_empty;
  logic    is_full;
  status_t status;

  modport source (output valid, output front_value, output rear_value, output count,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input front_value, input rear_value, input count,
                  input is_empty, input is_full, input status, output ready);
endinterface

@@ design/cdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/circular_double_ended_queue.sv @@
// Circular double-ended queue: top level with index control and result register.
// Usage:
//   in_chan carries one operation word (opcode, value): insert front, insert
//   rear, delete front, delete rear or status only. out_chan returns one
//   result word per operation: front and rear elements (all ones when empty),
//   element count (low 5 bits), empty and full flags and a status code
//   (ok, overflow on insert into a full queue, underflow on delete from empty).
//   A word is accepted when valid and ready are both high.
// Timing:
//   An operation is accepted in the idle state; its result is registered when
//   the load state ends, and no new operation is taken before that. The load
//   state covers the registered read of the element store, which a delete
//   needs to fetch the new front or rear element. Front and rear elements are
//   also cached in registers, so inserts and status operations read nothing.
// Reset:
//   Synchronous, active low: the queue is empty, indices and count at zero.
//   The element store is not cleared; no entry is read before it is written.
// Stall:
//   The result register holds a valid result while out_chan.ready is low. One
//   more operation is still accepted; its result waits in the load state until it frees.
module circular_double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  cdq_in_if.sink       in_chan,
  cdq_out_if.source    out_chan
);

  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  // control and queue state
  cdq_state_t     state_r, state_nxt;
  logic [IW-1:0]  front_idx_r, front_idx_nxt;
  logic [IW-1:0]  rear_idx_r, rear_idx_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  word_t          front_val_r, front_val_nxt;
  word_t          rear_val_r, rear_val_nxt;
  status_t        pend_status_r, pend_status_nxt;
  logic           pend_rd_r, pend_rd_nxt;
  logic           pend_front_r, pend_front_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  word_t          out_front_r, out_front_nxt;
  word_t          out_rear_r, out_rear_nxt;
  count_t         out_count_r, out_count_nxt;
  logic           out_empty_r, out_empty_nxt;
  logic           out_full_r, out_full_nxt;
  status_t        out_status_r, out_status_nxt;

  // store port signals
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic           accept;
  logic           is_ins, is_del, q_empty, q_full, load_ok;
  logic [IW-1:0]  front_up, front_down, rear_up, rear_down;
  word_t          new_front, new_rear;

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_chan.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // wrapping index steps
  assign front_up   = (front_idx_r == LAST_IDX) ? '0 : front_idx_r + 1'b1;
  assign front_down = (front_idx_r == '0) ? LAST_IDX : front_idx_r - 1'b1;
  assign rear_up    = (rear_idx_r == LAST_IDX) ? '0 : rear_idx_r + 1'b1;
  assign rear_down  = (rear_idx_r == '0) ? LAST_IDX : rear_idx_r - 1'b1;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_ins  = (in_chan.opcode == OP_INS_FRONT) || (in_chan.opcode == OP_INS_REAR);
  assign is_del  = (in_chan.opcode == OP_DEL_FRONT) || (in_chan.opcode == OP_DEL_REAR);
  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == FULL_CNT);
  assign load_ok = !out_valid_r || out_chan.ready;

  // elements after the operation, with the fresh read forwarded
  assign new_front = (pend_rd_r && pend_front_r)  ? word_t'(rd_data) : front_val_r;
  assign new_rear  = (pend_rd_r && !pend_front_r) ? word_t'(rd_data) : rear_val_r;

  // next state, index update and result load
  always_comb begin
    state_nxt       = state_r;
    front_idx_nxt   = front_idx_r;
    rear_idx_nxt    = rear_idx_r;
    count_nxt       = count_r;
    front_val_nxt   = front_val_r;
    rear_val_nxt    = rear_val_r;
    pend_status_nxt = pend_status_r;
    pend_rd_nxt     = pend_rd_r;
    pend_front_nxt  = pend_front_r;
    out_valid_nxt   = out_valid_r;
    out_front_nxt   = out_front_r;
    out_rear_nxt    = out_rear_r;
    out_count_nxt   = out_count_r;
    out_empty_nxt   = out_empty_r;
    out_full_nxt    = out_full_r;
    out_status_nxt  = out_status_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt       = ST_LOAD;
          pend_status_nxt = STAT_OK;
          pend_rd_nxt     = 1'b0;
          pend_front_nxt  = 1'b0;
          if (is_ins) begin
            if (q_full) begin
              pend_status_nxt = STAT_OVERFLOW;
            end else begin
              count_nxt = count_r + 1'b1;
              wr_en     = 1'b1;
              if (q_empty) begin
                front_idx_nxt = '0;
                rear_idx_nxt  = '0;
                wr_addr       = '0;
                front_val_nxt = in_chan.value;
                rear_val_nxt  = in_chan.value;
              end else if (in_chan.opcode == OP_INS_FRONT) begin
                front_idx_nxt = front_down;
                wr_addr       = front_down;
                front_val_nxt = in_chan.value;
              end else begin
                rear_idx_nxt = rear_up;
                wr_addr      = rear_up;
                rear_val_nxt = in_chan.value;
              end
            end
          end else if (is_del) begin
            if (q_empty) begin
              pend_status_nxt = STAT_UNDERFLOW;
            end else begin
              count_nxt = count_r - 1'b1;
              if (count_r == ONE_CNT) begin
                front_idx_nxt = '0;
                rear_idx_nxt  = '0;
              end else if (in_chan.opcode == OP_DEL_FRONT) begin
                front_idx_nxt  = front_up;
                rd_en          = 1'b1;
                rd_addr        = front_up;
                pend_rd_nxt    = 1'b1;
                pend_front_nxt = 1'b1;
              end else begin
                rear_idx_nxt = rear_down;
                rd_en        = 1'b1;
                rd_addr      = rear_down;
                pend_rd_nxt  = 1'b1;
              end
            end
          end
        end
      end
      ST_LOAD: begin
        if (load_ok) begin
          state_nxt      = ST_IDLE;
          front_val_nxt  = new_front;
          rear_val_nxt   = new_rear;
          pend_rd_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_front_nxt  = q_empty ? EMPTY_VALUE : new_front;
          out_rear_nxt   = q_empty ? EMPTY_VALUE : new_rear;
          out_count_nxt  = count_t'(count_r);
          out_empty_nxt  = q_empty;
          out_full_nxt   = q_full;
          out_status_nxt = pend_status_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_idx_r <= '0;
      rear_idx_r  <= '0;
      count_r     <= '0;
      pend_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      rear_idx_r  <= rear_idx_nxt;
      count_r     <= count_nxt;
      pend_rd_r   <= pend_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    front_val_r   <= front_val_nxt;
    rear_val_r    <= rear_val_nxt;
    pend_status_r <= pend_status_nxt;
    pend_front_r  <= pend_front_nxt;
    out_front_r   <= out_front_nxt;
    out_rear_r    <= out_rear_nxt;
    out_count_r   <= out_count_nxt;
    out_empty_r   <= out_empty_nxt;
    out_full_r    <= out_full_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.front_value = out_front_r;
  assign out_chan.rear_value  = out_rear_r;
  assign out_chan.count       = out_count_r;
  assign out_chan.is_empty    = out_empty_r;
  assign out_chan.is_full     = out_full_r;
  assign out_chan.status      = out_status_r;

`ifndef SYNTHESIS
  // count never passes capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("element count above capacity");

  // an empty queue keeps both indices at zero
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_idx_r == '0 && rear_idx_r == '0))
    else $error("empty queue with nonzero index");

  // overflow is only reported against a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == STAT_OVERFLOW) |-> out_chan.is_full)
    else $error("overflow reported while not full");

  // a pending store read is only taken after a delete that left elements
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && pend_rd_r) |-> (count_r != '0))
    else $error("store read pending on empty queue");
`endif

endmodule
